/* rtl/core/rbi_pkg.sv */
// shared widths, codes and sideband types of the ray/box intersection pipeline
package rbi_pkg;

	localparam int AXES = 3;
	localparam int ORG_W = 32;
	localparam int DIR_W = 32;
	localparam int SIZE_W = 31;
	localparam int DIST_W = 32;
	localparam int NUM_W = 34;
	localparam int SQ_W = 2 * DIR_W;
	localparam int SUM_W = 64;
	localparam int ROOT_W = 64;
	localparam int REM_W = ROOT_W + 2;
	localparam int OK_W = ORG_W + DIR_W;
	localparam int NK_W = NUM_W + DIR_W;
	localparam int LIM_W = DIR_W + SIZE_W;
	localparam int V_W = 68;
	localparam int PP_W = NUM_W + 32;
	localparam int PROD_W = NUM_W + ROOT_W;
	localparam int DVD_W = PROD_W - 33;
	localparam int QUO_W = 32;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_BOX_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BOX_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BOX_Z = 2'd2;

	typedef struct packed {
		logic hit;
		logic extra;
		logic neg0;
		logic neg1;
		logic [NUM_W-1:0] num0;
		logic [NUM_W-1:0] num1;
		logic [DIR_W-1:0] kmag0;
		logic [DIR_W-1:0] kmag1;
	} ray_side_t;

	typedef struct packed {
		logic hit;
		logic extra;
		logic neg;
	} div_side_t;

	// axis j (0 or 1) of the two axes other than a
	function automatic logic [1:0] other_axis(input int a, input int j);
		int b;
		b = a + 1 + j;
		if (b >= AXES) begin
			b = b - AXES;
		end
		return 2'(b);
	endfunction

endpackage

/* rtl/core/rbi_sqrt.sv */
// pipelined integer square root, one result bit per stage, with sideband
module rbi_sqrt #(
	parameter int SIDE_W = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [rbi_pkg::SUM_W-1:0]   in_sum,
	input  logic [SIDE_W-1:0]           in_side,
	output logic                        out_valid,
	output logic [rbi_pkg::ROOT_W-1:0]  out_root,
	output logic [SIDE_W-1:0]           out_side
);
	localparam int STEPS = rbi_pkg::ROOT_W;
	localparam int REM_W = rbi_pkg::REM_W;
	localparam int ROOT_W = rbi_pkg::ROOT_W;
	localparam int SUM_W = rbi_pkg::SUM_W;

	logic              vld_q  [STEPS];
	logic [REM_W-1:0]  rem_q  [STEPS];
	logic [ROOT_W-1:0] root_q [STEPS];
	logic [SUM_W-1:0]  rad_q  [STEPS];
	logic [SIDE_W-1:0] side_q [STEPS];

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic              p_vld;
		logic [REM_W-1:0]  p_rem;
		logic [ROOT_W-1:0] p_root;
		logic [SUM_W-1:0]  p_rad;
		logic [SIDE_W-1:0] p_side;
		logic [REM_W-1:0]  cur;
		logic [REM_W-1:0]  trial;
		logic              ge;

		if (i == 0) begin : g_first
			assign p_vld = in_valid;
			assign p_rem = '0;
			assign p_root = '0;
			assign p_rad = in_sum;
			assign p_side = in_side;
		end else begin : g_next
			assign p_vld = vld_q[i-1];
			assign p_rem = rem_q[i-1];
			assign p_root = root_q[i-1];
			assign p_rad = rad_q[i-1];
			assign p_side = side_q[i-1];
		end

		assign cur = {p_rem[REM_W-3:0], p_rad[SUM_W-1 -: 2]};
		assign trial = {p_root, 2'b01};
		assign ge = (cur >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[i] <= 1'b0;
			end else if (en) begin
				vld_q[i] <= p_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[i] <= ge ? cur - trial : cur;
				root_q[i] <= {p_root[ROOT_W-2:0], ge};
				rad_q[i] <= p_rad << 2;
				side_q[i] <= p_side;
			end
		end
	end

	assign out_valid = vld_q[STEPS-1];
	assign out_root = root_q[STEPS-1];
	assign out_side = side_q[STEPS-1];

endmodule

/* rtl/core/rbi_div.sv */
// pipelined restoring divider: a preparation stage, then one quotient bit per stage, with overflow flag
module rbi_div #(
	parameter int SIDE_W = 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [rbi_pkg::DVD_W-1:0]  in_dvd,
	input  logic [rbi_pkg::DIR_W-1:0]  in_dsr,
	input  logic [SIDE_W-1:0]          in_side,
	output logic                       out_valid,
	output logic [rbi_pkg::QUO_W-1:0]  out_quo,
	output logic                       out_ovf,
	output logic [SIDE_W-1:0]          out_side
);
	localparam int QUO_W = rbi_pkg::QUO_W;
	localparam int DSR_W = rbi_pkg::DIR_W;
	localparam int DVD_W = rbi_pkg::DVD_W;
	localparam int STEPS = QUO_W + 1;

	logic              vld_q  [STEPS];
	logic [DSR_W-1:0]  rem_q  [STEPS];
	logic [QUO_W-1:0]  low_q  [STEPS];
	logic [DSR_W-1:0]  dsr_q  [STEPS];
	logic              ovf_q  [STEPS];
	logic [SIDE_W-1:0] side_q [STEPS];

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		if (i == 0) begin : g_prep
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_q[i] <= 1'b0;
				end else if (en) begin
					vld_q[i] <= in_valid;
				end
			end

			// quotient fits in QUO_W bits only when the upper part is below the divisor
			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[i] <= in_dvd[QUO_W +: DSR_W];
					ovf_q[i] <= (in_dvd[DVD_W-1:QUO_W] >= {1'b0, in_dsr});
					low_q[i] <= in_dvd[QUO_W-1:0];
					dsr_q[i] <= in_dsr;
					side_q[i] <= in_side;
				end
			end
		end else begin : g_bit
			logic [DSR_W:0] cur;
			logic [DSR_W:0] sub;
			logic           ge;

			assign cur = {rem_q[i-1], low_q[i-1][QUO_W-1]};
			assign sub = cur - {1'b0, dsr_q[i-1]};
			assign ge = (cur >= {1'b0, dsr_q[i-1]});

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_q[i] <= 1'b0;
				end else if (en) begin
					vld_q[i] <= vld_q[i-1];
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[i] <= ge ? sub[DSR_W-1:0] : cur[DSR_W-1:0];
					low_q[i] <= {low_q[i-1][QUO_W-2:0], ge};
					ovf_q[i] <= ovf_q[i-1];
					dsr_q[i] <= dsr_q[i-1];
					side_q[i] <= side_q[i-1];
				end
			end
		end
	end

	assign out_valid = vld_q[STEPS-1];
	assign out_quo = low_q[STEPS-1];
	assign out_ovf = ovf_q[STEPS-1];
	assign out_side = side_q[STEPS-1];

endmodule

/* rtl/core/ray_box_intersection.sv */
// ray / axis-aligned box intersection: fixed-point pipeline, one ray per cycle
//
// A ray (origin relative to the box centre, direction of any length) is a
// transfer on the in channel (in_valid/in_ready); the result (hit, entry and
// exit distance, extra-hit and saturation flags) is a transfer on the out
// channel (out_valid/out_ready). Box extents are written through cfg_we,
// cfg_index and cfg_data; the user must write them only while no ray is in
// flight; the block does not enforce it. The path holds five face-test stages,
// 64 square-root stages, two product stages, 33 divider stages, one sign
// and saturation stage and the output buffer; one ray per cycle unless held.
// A two-entry output buffer sits behind the pipeline; the whole pipeline
// advances together and holds only while that buffer is full, so a stalled
// receiver first fills the buffer and then deasserts in_ready. Nothing is
// lost or repeated across a stall.
// Reset clears all valid bits and the buffer and sets every extent to 1.0.
module ray_box_intersection #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [rbi_pkg::ORG_W-1:0]     origin_x,
	input  logic signed [rbi_pkg::ORG_W-1:0]     origin_y,
	input  logic signed [rbi_pkg::ORG_W-1:0]     origin_z,
	input  logic signed [rbi_pkg::DIR_W-1:0]     dir_x,
	input  logic signed [rbi_pkg::DIR_W-1:0]     dir_y,
	input  logic signed [rbi_pkg::DIR_W-1:0]     dir_z,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 hit,
	output logic signed [rbi_pkg::DIST_W-1:0]    dist_in,
	output logic signed [rbi_pkg::DIST_W-1:0]    dist_out,
	output logic                                 extra_hits,
	output logic                                 saturated,
	input  logic                                 cfg_we,
	input  logic [rbi_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [rbi_pkg::SIZE_W-1:0]           cfg_data
);
	localparam int AXES = rbi_pkg::AXES;
	localparam int ORG_W = rbi_pkg::ORG_W;
	localparam int DIR_W = rbi_pkg::DIR_W;
	localparam int SIZE_W = rbi_pkg::SIZE_W;
	localparam int DIST_W = rbi_pkg::DIST_W;
	localparam int NUM_W = rbi_pkg::NUM_W;
	localparam int SQ_W = rbi_pkg::SQ_W;
	localparam int SUM_W = rbi_pkg::SUM_W;
	localparam int ROOT_W = rbi_pkg::ROOT_W;
	localparam int OK_W = rbi_pkg::OK_W;
	localparam int NK_W = rbi_pkg::NK_W;
	localparam int LIM_W = rbi_pkg::LIM_W;
	localparam int V_W = rbi_pkg::V_W;
	localparam int PP_W = rbi_pkg::PP_W;
	localparam int PROD_W = rbi_pkg::PROD_W;
	localparam int DVD_W = rbi_pkg::DVD_W;
	localparam int QUO_W = rbi_pkg::QUO_W;
	localparam int HALF_W = ROOT_W / 2;
	localparam logic [SIZE_W-1:0] RST_SIZE = SIZE_W'(64'd1 << FRAC_BITS);
	localparam logic [DIST_W-1:0] POS_LIM = {1'b0, {(DIST_W-1){1'b1}}};
	localparam logic [DIST_W-1:0] NEG_LIM = {1'b1, {(DIST_W-1){1'b0}}};

	typedef struct packed {
		logic                     hit;
		logic signed [DIST_W-1:0] din;
		logic signed [DIST_W-1:0] dout;
		logic                     extra;
		logic                     sat;
	} result_t;

	logic [SIZE_W-1:0] sz_q [AXES];
	logic              en;

	// box extent registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < AXES; a++) begin
				sz_q[a] <= RST_SIZE;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				rbi_pkg::CFG_BOX_X: sz_q[0] <= cfg_data;
				rbi_pkg::CFG_BOX_Y: sz_q[1] <= cfg_data;
				rbi_pkg::CFG_BOX_Z: sz_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1: magnitudes, squares, face offsets
	logic signed [ORG_W-1:0] in_o [AXES];
	logic signed [DIR_W-1:0] in_k [AXES];
	logic [DIR_W-1:0]        kmag_c [AXES];
	logic [SQ_W-1:0]         sq_c [AXES];
	logic signed [NUM_W-1:0] num_c [AXES][2];

	assign in_o[0] = origin_x;
	assign in_o[1] = origin_y;
	assign in_o[2] = origin_z;
	assign in_k[0] = dir_x;
	assign in_k[1] = dir_y;
	assign in_k[2] = dir_z;

	always_comb begin
		logic [NUM_W-1:0] two_o;
		logic [NUM_W-1:0] nsz;
		for (int a = 0; a < AXES; a++) begin
			two_o = {in_o[a][ORG_W-1], in_o[a], 1'b0};
			nsz = {{(NUM_W-SIZE_W){1'b0}}, sz_q[a]};
			kmag_c[a] = in_k[a][DIR_W-1] ? DIR_W'(-in_k[a]) : DIR_W'(in_k[a]);
			sq_c[a] = kmag_c[a] * kmag_c[a];
			num_c[a][0] = '0 - nsz - two_o;
			num_c[a][1] = nsz - two_o;
		end
	end

	logic                    vld_s1;
	logic signed [ORG_W-1:0] o_s1 [AXES];
	logic signed [DIR_W-1:0] k_s1 [AXES];
	logic [DIR_W-1:0]        kmag_s1 [AXES];
	logic [SQ_W-1:0]         sq_s1 [AXES];
	logic signed [NUM_W-1:0] num_s1 [AXES][2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			o_s1 <= in_o;
			k_s1 <= in_k;
			kmag_s1 <= kmag_c;
			sq_s1 <= sq_c;
			num_s1 <= num_c;
		end
	end

	// stage 2: cross products for the face tests, squared length
	logic                    vld_s2;
	logic [SUM_W-1:0]        sum_s2;
	logic signed [OK_W-1:0]  pok_s2 [AXES][2];
	logic signed [NK_W-1:0]  pnk_s2 [AXES][2][2];
	logic [LIM_W-1:0]        lim_s2 [AXES][2];
	logic signed [NUM_W-1:0] num_s2 [AXES][2];
	logic [DIR_W-1:0]        kmag_s2 [AXES];
	logic                    kneg_s2 [AXES];
	logic                    knz_s2 [AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2 <= sq_s1[0] + sq_s1[1] + sq_s1[2];
			for (int a = 0; a < AXES; a++) begin
				for (int j = 0; j < 2; j++) begin
					pok_s2[a][j] <= o_s1[rbi_pkg::other_axis(a, j)] * k_s1[a];
					lim_s2[a][j] <= kmag_s1[a] * sz_q[rbi_pkg::other_axis(a, j)];
					for (int s = 0; s < 2; s++) begin
						pnk_s2[a][s][j] <= num_s1[a][s] * k_s1[rbi_pkg::other_axis(a, j)];
					end
				end
				kneg_s2[a] <= k_s1[a][DIR_W-1];
				knz_s2[a] <= (k_s1[a] != '0);
			end
			num_s2 <= num_s1;
			kmag_s2 <= kmag_s1;
		end
	end

	// stage 3: scaled hit coordinates on the other two axes
	logic                    vld_s3;
	logic [SUM_W-1:0]        sum_s3;
	logic signed [V_W-1:0]   v_s3 [AXES][2][2];
	logic [LIM_W-1:0]        lim_s3 [AXES][2];
	logic signed [NUM_W-1:0] num_s3 [AXES][2];
	logic [DIR_W-1:0]        kmag_s3 [AXES];
	logic                    kneg_s3 [AXES];
	logic                    knz_s3 [AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < AXES; a++) begin
				for (int s = 0; s < 2; s++) begin
					for (int j = 0; j < 2; j++) begin
						v_s3[a][s][j] <=
							{{(V_W-OK_W-1){pok_s2[a][j][OK_W-1]}}, pok_s2[a][j], 1'b0} +
							{{(V_W-NK_W){pnk_s2[a][s][j][NK_W-1]}}, pnk_s2[a][s][j]};
					end
				end
			end
			sum_s3 <= sum_s2;
			lim_s3 <= lim_s2;
			num_s3 <= num_s2;
			kmag_s3 <= kmag_s2;
			kneg_s3 <= kneg_s2;
			knz_s3 <= knz_s2;
		end
	end

	// stage 4: strict inside tests, one flag per face
	logic [2*AXES-1:0] ins_c;

	always_comb begin
		logic signed [V_W-1:0] limx;
		logic                  ok;
		for (int a = 0; a < AXES; a++) begin
			for (int s = 0; s < 2; s++) begin
				ok = knz_s3[a];
				for (int j = 0; j < 2; j++) begin
					limx = {{(V_W-LIM_W){1'b0}}, lim_s3[a][j]};
					ok = ok && (v_s3[a][s][j] < limx) && (v_s3[a][s][j] > -limx);
				end
				ins_c[2*a+s] = ok;
			end
		end
	end

	logic                    vld_s4;
	logic [SUM_W-1:0]        sum_s4;
	logic [2*AXES-1:0]       ins_s4;
	logic signed [NUM_W-1:0] num_s4 [AXES][2];
	logic [DIR_W-1:0]        kmag_s4 [AXES];
	logic                    kneg_s4 [AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s4 <= sum_s3;
			ins_s4 <= ins_c;
			num_s4 <= num_s3;
			kmag_s4 <= kmag_s3;
			kneg_s4 <= kneg_s3;
		end
	end

	// stage 5: keep the first two face hits in face order
	rbi_pkg::ray_side_t side_c;

	always_comb begin
		logic                    have0;
		logic                    have1;
		logic                    many;
		logic [2:0]              sel0;
		logic [2:0]              sel1;
		logic signed [NUM_W-1:0] n0;
		logic signed [NUM_W-1:0] n1;
		have0 = 1'b0;
		have1 = 1'b0;
		many = 1'b0;
		sel0 = '0;
		sel1 = '0;
		for (int i = 0; i < 2 * AXES; i++) begin
			if (ins_s4[i]) begin
				if (!have0) begin
					sel0 = 3'(i);
					have0 = 1'b1;
				end else if (!have1) begin
					sel1 = 3'(i);
					have1 = 1'b1;
				end else begin
					many = 1'b1;
				end
			end
		end
		// single hit: exit equals entry
		if (!have1) begin
			sel1 = sel0;
		end
		n0 = num_s4[sel0[2:1]][sel0[0]];
		n1 = num_s4[sel1[2:1]][sel1[0]];
		side_c.hit = have0;
		side_c.extra = many;
		side_c.neg0 = n0[NUM_W-1] ^ kneg_s4[sel0[2:1]];
		side_c.neg1 = n1[NUM_W-1] ^ kneg_s4[sel1[2:1]];
		side_c.num0 = n0[NUM_W-1] ? NUM_W'(-n0) : NUM_W'(n0);
		side_c.num1 = n1[NUM_W-1] ? NUM_W'(-n1) : NUM_W'(n1);
		side_c.kmag0 = kmag_s4[sel0[2:1]];
		side_c.kmag1 = kmag_s4[sel1[2:1]];
	end

	logic               vld_s5;
	logic [SUM_W-1:0]   sum_s5;
	rbi_pkg::ray_side_t side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s5 <= sum_s4;
			side_s5 <= side_c;
		end
	end

	// direction length, scaled by 2^32
	logic                         sq_vld;
	logic [ROOT_W-1:0]            sq_root;
	logic [$bits(rbi_pkg::ray_side_t)-1:0] sq_side_bits;
	rbi_pkg::ray_side_t           sq_side;

	rbi_sqrt #(
		.SIDE_W($bits(rbi_pkg::ray_side_t))
	) u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(vld_s5),
		.in_sum(sum_s5),
		.in_side(side_s5),
		.out_valid(sq_vld),
		.out_root(sq_root),
		.out_side(sq_side_bits)
	);

	assign sq_side = rbi_pkg::ray_side_t'(sq_side_bits);

	// stage 6: partial products of offset times length
	logic               vld_s6;
	logic [PP_W-1:0]    pplo_s6 [2];
	logic [PP_W-1:0]    pphi_s6 [2];
	rbi_pkg::ray_side_t side_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pplo_s6[0] <= sq_side.num0 * sq_root[HALF_W-1:0];
			pphi_s6[0] <= sq_side.num0 * sq_root[ROOT_W-1:HALF_W];
			pplo_s6[1] <= sq_side.num1 * sq_root[HALF_W-1:0];
			pphi_s6[1] <= sq_side.num1 * sq_root[ROOT_W-1:HALF_W];
			side_s6 <= sq_side;
		end
	end

	// stage 7: full product, dropping the 2^33 scale
	logic               vld_s7;
	logic [DVD_W-1:0]   dvd_s7 [2];
	rbi_pkg::ray_side_t side_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		logic [PROD_W-1:0] prod;
		if (en) begin
			for (int j = 0; j < 2; j++) begin
				prod = {{(PROD_W-PP_W){1'b0}}, pplo_s6[j]} +
					{pphi_s6[j][PROD_W-HALF_W-1:0], {HALF_W{1'b0}}};
				dvd_s7[j] <= prod[PROD_W-1 -: DVD_W];
			end
			side_s7 <= side_s6;
		end
	end

	// distance magnitudes
	rbi_pkg::div_side_t div0_side_in;
	logic [$bits(rbi_pkg::div_side_t)-1:0] div0_side_bits;
	rbi_pkg::div_side_t div0_side;
	logic               div0_vld;
	logic               div1_vld;
	logic [QUO_W-1:0]   quo [2];
	logic               ovf [2];
	logic               div1_neg;

	assign div0_side_in.hit = side_s7.hit;
	assign div0_side_in.extra = side_s7.extra;
	assign div0_side_in.neg = side_s7.neg0;

	rbi_div #(
		.SIDE_W($bits(rbi_pkg::div_side_t))
	) u_div0 (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(vld_s7),
		.in_dvd(dvd_s7[0]),
		.in_dsr(side_s7.kmag0),
		.in_side(div0_side_in),
		.out_valid(div0_vld),
		.out_quo(quo[0]),
		.out_ovf(ovf[0]),
		.out_side(div0_side_bits)
	);

	rbi_div #(
		.SIDE_W(1)
	) u_div1 (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(vld_s7),
		.in_dvd(dvd_s7[1]),
		.in_dsr(side_s7.kmag1),
		.in_side(side_s7.neg1),
		.out_valid(div1_vld),
		.out_quo(quo[1]),
		.out_ovf(ovf[1]),
		.out_side(div1_neg)
	);

	assign div0_side = rbi_pkg::div_side_t'(div0_side_bits);

	// stage 8: sign and saturation
	logic                     dneg [2];
	logic signed [DIST_W-1:0] d_c [2];
	logic                     sat_c [2];

	assign dneg[0] = div0_side.neg;
	assign dneg[1] = div1_neg;

	always_comb begin
		logic [DIST_W-1:0] lim;
		logic [DIST_W-1:0] m;
		for (int j = 0; j < 2; j++) begin
			lim = dneg[j] ? NEG_LIM : POS_LIM;
			sat_c[j] = ovf[j] || (quo[j] > lim);
			m = sat_c[j] ? lim : quo[j];
			d_c[j] = dneg[j] ? -m : m;
		end
	end

	logic                     vld_s8;
	logic                     hit_s8;
	logic                     extra_s8;
	logic                     sat_s8;
	logic signed [DIST_W-1:0] d0_s8;
	logic signed [DIST_W-1:0] d1_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s8 <= div0_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s8 <= div0_side.hit;
			extra_s8 <= div0_side.extra;
			sat_s8 <= div0_side.hit && (sat_c[0] || sat_c[1]);
			d0_s8 <= div0_side.hit ? d_c[0] : '0;
			d1_s8 <= div0_side.hit ? d_c[1] : '0;
		end
	end

	// order and output buffer
	result_t res_c;

	always_comb begin
		res_c.hit = hit_s8;
		res_c.extra = extra_s8;
		res_c.sat = sat_s8;
		if (d1_s8 < d0_s8) begin
			res_c.din = d1_s8;
			res_c.dout = d0_s8;
		end else begin
			res_c.din = d0_s8;
			res_c.dout = d1_s8;
		end
	end

	result_t    fifo_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign en = (cnt_q != 2'd2);
	assign in_ready = en;
	assign push = en && vld_s8;
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= res_c;
		end
	end

	assign out_valid = (cnt_q != 2'd0);
	assign hit = fifo_q[rd_q].hit;
	assign dist_in = fifo_q[rd_q].din;
	assign dist_out = fifo_q[rd_q].dout;
	assign extra_hits = fifo_q[rd_q].extra;
	assign saturated = fifo_q[rd_q].sat;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output buffer count out of range");

	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		div0_vld == div1_vld)
		else $error("divider lanes out of step");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> dist_in == '0 && dist_out == '0 && !saturated && !extra_hits)
		else $error("miss with nonzero result");

	a_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> dist_in <= dist_out)
		else $error("entry distance beyond exit distance");

endmodule
